// ----- design/decimal_digit_glyph_emitter_top_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef DECIMAL_DIGIT_GLYPH_EMITTER_TOP_MACROS_SVH
`define DECIMAL_DIGIT_GLYPH_EMITTER_TOP_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define DDGE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked property that is also checked across reset.
`define DDGE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- design/ddge_pkg.sv -----
package ddge_pkg;

    localparam int MAX_DIGITS = 5;
    localparam int VALUE_BITS = 16;

    localparam int CNT_W   = 3;
    localparam int CFG_W   = 3;
    localparam int CFG_IDX_W = 2;
    localparam int DIGIT_W = 4;
    localparam int X_W     = 8;
    localparam int Y_W     = 8;
    localparam int TAG_W   = 2;
    localparam int GX_W    = 9;
    localparam int TILE_W  = 8;

    localparam int TILE_BASE = 88;
    localparam int X_STEP    = 8;
    localparam int COUNT_RESET = 3;

    localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_FILL   = CFG_IDX_W'(1);

    function automatic logic [63:0] pow10(input int p);
        logic [63:0] r;
        r = 64'd1;
        for (int i = 0; i < p; i++)
        begin
            r = r * 64'd10;
        end
        return r;
    endfunction

    // Saturated value is below 10^MAX_DIGITS.
    localparam int SAT_W = $clog2(pow10(MAX_DIGITS));
    localparam int CMP_W = (SAT_W > VALUE_BITS) ? SAT_W : VALUE_BITS;
    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    // Reciprocal of ten, exact floor for every value below 2^SAT_W.
    localparam int DIV_SHIFT = SAT_W + 4;
    localparam int RECIP_W   = DIV_SHIFT - 2;
    localparam logic [63:0] RECIP = ((64'd1 << DIV_SHIFT) / 64'd10) + 64'd1;
    localparam int PROD_W    = SAT_W + RECIP_W;

    typedef logic [MAX_DIGITS-1:0][DIGIT_W-1:0] ddge_digits_t;

    typedef struct packed {
        logic [SAT_W-1:0] rem;
        ddge_digits_t     digits;
        logic [CNT_W-1:0] n;
        logic [X_W-1:0]   sx;
        logic [Y_W-1:0]   sy;
        logic [TAG_W-1:0] tag;
    } ddge_item_t;

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] r;
        r = n;
        if (n == '0)
        begin
            r = CNT_W'(1);
        end
        else if (int'(n) > MAX_DIGITS)
        begin
            r = CNT_W'(MAX_DIGITS);
        end
        return r;
    endfunction

    // Largest value shown in n digit positions.
    function automatic logic [SAT_W-1:0] digit_limit(input logic [CNT_W-1:0] n);
        logic [63:0] r;
        r = 64'd0;
        for (int i = 1; i <= MAX_DIGITS; i++)
        begin
            if (int'(n) == i)
            begin
                r = pow10(i) - 64'd1;
            end
        end
        return r[SAT_W-1:0];
    endfunction

endpackage

// ----- design/ddge_cell.sv -----
module ddge_cell import ddge_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  ddge_item_t in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output ddge_item_t out_item
);

    logic              valid_reg;
    logic              valid_next;
    ddge_item_t        item_reg;
    logic [PROD_W-1:0] prod;
    logic [SAT_W-1:0]  quot;
    logic [SAT_W-1:0]  times10;
    logic [SAT_W-1:0]  rest;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;

    always_comb
    begin
        prod    = PROD_W'(item_reg.rem) * PROD_W'(RECIP[RECIP_W-1:0]);
        quot    = SAT_W'(prod >> DIV_SHIFT);
        times10 = SAT_W'({quot, 3'b000}) + SAT_W'({quot, 1'b0});
        rest    = item_reg.rem - times10;

        // Drop the low digit into the top slot and shift the rest down.
        out_item     = item_reg;
        out_item.rem = quot;
        for (int i = 0; i < MAX_DIGITS - 1; i++)
        begin
            out_item.digits[i] = item_reg.digits[i+1];
        end
        out_item.digits[MAX_DIGITS-1] = rest[DIGIT_W-1:0];

        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ----- design/ddge_emit.sv -----
module ddge_emit import ddge_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              zero_fill,
    input  logic              in_valid,
    output logic              in_ready,
    input  ddge_item_t        in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [GX_W-1:0]   glyph_x,
    output logic [Y_W-1:0]    glyph_y,
    output logic [TILE_W-1:0] tile_index,
    output logic [TAG_W-1:0]  target_out,
    output logic              last
);

    logic               busy_reg,    busy_next;
    logic               out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]   pos_reg,     pos_next;
    logic [CNT_W-1:0]   n_reg,       n_next;
    ddge_digits_t       digits_reg,  digits_next;
    logic [GX_W-1:0]    x_reg,       x_next;
    logic [Y_W-1:0]     y_reg,       y_next;
    logic [TAG_W-1:0]   tag_reg,     tag_next;
    logic               showing_reg, showing_next;

    logic [GX_W-1:0]    gx_reg;
    logic [Y_W-1:0]     gy_reg;
    logic [TILE_W-1:0]  tile_reg;
    logic [TAG_W-1:0]   tgt_reg;
    logic               last_reg;

    logic [IDX_W-1:0]   idx;
    logic [DIGIT_W-1:0] digit;
    logic [TILE_W-1:0]  tile;
    logic               final_pos;
    logic               show;
    logic               out_free;
    logic               step;
    logic               load;

    assign out_valid  = out_valid_reg;
    assign glyph_x    = gx_reg;
    assign glyph_y    = gy_reg;
    assign tile_index = tile_reg;
    assign target_out = tgt_reg;
    assign last       = last_reg;

    always_comb
    begin
        idx       = IDX_W'(n_reg - pos_reg - CNT_W'(1));
        digit     = digits_reg[idx];
        tile      = TILE_W'({digit, 3'b000}) + TILE_W'(TILE_BASE);
        final_pos = (pos_reg == n_reg - CNT_W'(1));
        show      = showing_reg || (digit != '0) || final_pos;
        out_free  = !out_valid_reg || out_ready;
        step      = busy_reg && out_free;
        in_ready  = !busy_reg || (step && final_pos);
        load      = in_valid && in_ready;

        busy_next    = busy_reg;
        pos_next     = pos_reg;
        n_next       = n_reg;
        digits_next  = digits_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        tag_next     = tag_reg;
        showing_next = showing_reg;

        // Every digit position takes one step; blanked ones only advance x.
        if (step)
        begin
            pos_next     = pos_reg + CNT_W'(1);
            x_next       = x_reg + GX_W'(X_STEP);
            showing_next = showing_reg || show;
            if (final_pos)
            begin
                busy_next = 1'b0;
            end
        end

        out_valid_next = out_valid_reg && !out_ready;
        if (step && show)
        begin
            out_valid_next = 1'b1;
        end

        if (load)
        begin
            busy_next    = 1'b1;
            pos_next     = '0;
            n_next       = in_item.n;
            digits_next  = in_item.digits;
            x_next       = {1'b0, in_item.sx};
            y_next       = in_item.sy;
            tag_next     = in_item.tag;
            showing_next = zero_fill;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        n_reg       <= n_next;
        digits_reg  <= digits_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        tag_reg     <= tag_next;
        showing_reg <= showing_next;
        if (step && show)
        begin
            gx_reg   <= x_reg;
            gy_reg   <= y_reg;
            tile_reg <= tile;
            tgt_reg  <= tag_reg;
            last_reg <= final_pos;
        end
    end

endmodule

// ----- design/decimal_digit_glyph_emitter_top.sv -----
// Decimal digit glyph emitter.
// Input channel (in_valid/in_ready) takes one beat per number: value, start_x,
// start_y and target. Output channel (out_valid/out_ready) gives one beat per
// shown digit glyph, most significant first, with last on the final digit.
// The value is saturated to the largest number that fits in digit_count
// positions; leading zeros are blanked unless zero_fill is set.
// Configuration: cfg_wr_en with cfg_index (0 digit_count, 1 zero_fill) and
// cfg_data; write only while the block is idle.
// A row of MAX_DIGITS divide-by-ten cells peels off one digit per cell per
// cycle unless back pressure holds the row; the glyph stage then steps
// through every digit position of a number in turn, blanked leading ones
// included, so n positions (n = digit_count clamped to 1..MAX_DIGITS) per
// number set the throughput.
// The next number is taken on the cycle the last position is stepped.
// Reset clears all valid flags and sets digit_count to 3, zero_fill to 0.
// When the receiver stalls, the output beat holds, the glyph stage stops, and
// back pressure fills the cell row before in_ready drops.
module decimal_digit_glyph_emitter_top import ddge_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [VALUE_BITS-1:0] value,
    input  logic [X_W-1:0]        start_x,
    input  logic [Y_W-1:0]        start_y,
    input  logic [TAG_W-1:0]      target,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [GX_W-1:0]       glyph_x,
    output logic [Y_W-1:0]        glyph_y,
    output logic [TILE_W-1:0]     tile_index,
    output logic [TAG_W-1:0]      target_out,
    output logic                  last
);

    logic [CNT_W-1:0] digit_count_reg, digit_count_next;
    logic             zero_fill_reg,   zero_fill_next;

    logic [CNT_W-1:0] n_clamp;
    logic [SAT_W-1:0] limit;
    logic [CMP_W-1:0] val_ext;
    logic [CMP_W-1:0] lim_ext;
    ddge_item_t       front_item;

    logic       [MAX_DIGITS:0] chain_valid;
    logic       [MAX_DIGITS:0] chain_ready;
    ddge_item_t [MAX_DIGITS:0] chain_item;

    always_comb
    begin
        digit_count_next = digit_count_reg;
        zero_fill_next   = zero_fill_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_DIGIT_COUNT: digit_count_next = cfg_data;
                REG_ZERO_FILL:   zero_fill_next   = cfg_data[0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_count_reg <= CNT_W'(COUNT_RESET);
            zero_fill_reg   <= 1'b0;
        end
        else
        begin
            digit_count_reg <= digit_count_next;
            zero_fill_reg   <= zero_fill_next;
        end
    end

    // Saturate on the way in.
    always_comb
    begin
        n_clamp = clamp_count(digit_count_reg);
        limit   = digit_limit(n_clamp);
        val_ext = CMP_W'(value);
        lim_ext = CMP_W'(limit);

        front_item.rem    = SAT_W'((val_ext > lim_ext) ? lim_ext : val_ext);
        front_item.digits = '0;
        front_item.n      = n_clamp;
        front_item.sx     = start_x;
        front_item.sy     = start_y;
        front_item.tag    = target;
    end

    assign chain_valid[0] = in_valid;
    assign in_ready       = chain_ready[0];
    assign chain_item[0]  = front_item;

    for (genvar k = 0; k < MAX_DIGITS; k++)
    begin : g_cell
        ddge_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[k]),
            .in_ready  (chain_ready[k]),
            .in_item   (chain_item[k]),
            .out_valid (chain_valid[k+1]),
            .out_ready (chain_ready[k+1]),
            .out_item  (chain_item[k+1])
        );
    end

    ddge_emit u_emit
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .zero_fill  (zero_fill_reg),
        .in_valid   (chain_valid[MAX_DIGITS]),
        .in_ready   (chain_ready[MAX_DIGITS]),
        .in_item    (chain_item[MAX_DIGITS]),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .glyph_x    (glyph_x),
        .glyph_y    (glyph_y),
        .tile_index (tile_index),
        .target_out (target_out),
        .last       (last)
    );

endmodule

// ----- design/ddge_checker.sv -----
`include "decimal_digit_glyph_emitter_top_macros.svh"

module ddge_checker import ddge_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [GX_W-1:0]       glyph_x,
    input logic [Y_W-1:0]        glyph_y,
    input logic [TILE_W-1:0]     tile_index,
    input logic [TAG_W-1:0]      target_out,
    input logic                  last
);

    // A stalled output beat stays offered.
    `DDGE_ASSERT(a_out_hold, clk, rst_n,
        out_valid && !out_ready |=> out_valid,
        "out beat dropped while stalled")

    // A stalled output beat keeps its payload.
    `DDGE_ASSERT(a_out_stable, clk, rst_n,
        out_valid && !out_ready |=> $stable(glyph_x) && $stable(glyph_y)
            && $stable(tile_index) && $stable(target_out) && $stable(last),
        "out payload changed while stalled")

    // Tiles only ever name the ten digit glyphs.
    `DDGE_ASSERT(a_tile_range, clk, rst_n,
        out_valid |-> (tile_index >= TILE_W'(TILE_BASE))
            && (tile_index <= TILE_W'(TILE_BASE + 72)) && (tile_index[2:0] == 3'b000),
        "tile index outside the digit glyphs")

    // Nothing can be offered on the first edge after reset releases.
    `DDGE_ASSERT_ALWAYS(a_reset_quiet, clk,
        $rose(rst_n) |-> !out_valid,
        "output valid straight out of reset")

endmodule

bind decimal_digit_glyph_emitter_top ddge_checker u_ddge_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .glyph_x    (glyph_x),
    .glyph_y    (glyph_y),
    .tile_index (tile_index),
    .target_out (target_out),
    .last       (last)
);
